// ----- rtl/md5_stream_hasher_assert.svh -----
// ----------------------------------------------------------------------------
// md5_stream_hasher assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef MD5_STREAM_HASHER_ASSERT_SVH
`define MD5_STREAM_HASHER_ASSERT_SVH

// Same-cycle implication.
`define MD5SH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked a fixed number of cycles later.
`define MD5SH_ASSERT_LATER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ----- rtl/md5sh_pkg.sv -----
// ----------------------------------------------------------------------------
// md5sh_pkg
// Types, constants and round functions shared by the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_item;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  typedef enum logic [1:0] {
    BS_LOAD,
    BS_PAD,
    BS_COMP,
    BS_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } pad_phase_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_PRE,
    CS_RND,
    CS_FIN
  } comp_state_e;

  typedef struct packed {
    logic start;
    logic reinit;
  } comp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } comp_stat_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] ROUND_LAST = 6'd63;
  localparam logic [1:0] WORD_LAST  = 2'd3;

  // Input queue between the front and back parts.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_shift(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by round i.
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0:    g = i[3:0];
      2'd1:    g = 4'(4'd5 * i[3:0] + 4'd1);
      2'd2:    g = 4'(4'd3 * i[3:0] + 4'd5);
      2'd3:    g = 4'(4'd7 * i[3:0]);
      default: g = 4'd0;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] stage, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (stage)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = 32'h0;
    endcase
    return f;
  endfunction

endpackage

// ----- rtl/md5sh_front.sv -----
// ----------------------------------------------------------------------------
// md5sh_front
// Input side: takes items, drops those that carry neither byte nor end, and
// queues the rest for the back part.
// ----------------------------------------------------------------------------
module md5sh_front import md5sh_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  md5_in_t in_data_i,
  output logic    q_valid_o,
  output md5_in_t q_item_o,
  input  logic    q_pop_i
);

  md5_in_t          mem_q [QDEPTH];
  logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QAW:0]     cnt_q, cnt_d;
  logic             push;

  assign in_ready_o = (cnt_q != (QAW+1)'(QDEPTH));
  assign push       = in_valid_i && in_ready_o &&
                      (in_data_i.byte_present || in_data_i.last_item);
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + (QAW+1)'(1);
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (q_pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ----- rtl/md5sh_compress.sv -----
// ----------------------------------------------------------------------------
// md5sh_compress
// Iterative MD5 compression: one round per cycle, chaining words held here.
// ----------------------------------------------------------------------------
module md5sh_compress import md5sh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  comp_cmd_t        cmd_i,
  output logic [3:0]       w_idx_o,
  input  logic [31:0]      w_data_i,
  output comp_stat_t       stat_o,
  output logic [3:0][31:0] chain_o
);

  comp_state_e      st_q, st_d;
  logic [5:0]       cnt_q;
  logic [31:0]      a_q, b_q, c_q, d_q, kw_q;
  logic [3:0][31:0] chain_q;

  logic        load_en, kw_en, rnd_en, fin_en;
  logic [5:0]  next_i;
  logic [31:0] f, t, new_b, kw_next;
  logic [63:0] rot_w;

  always_comb begin
    case (st_q)
      CS_IDLE: st_d = cmd_i.start ? CS_PRE : CS_IDLE;
      CS_PRE:  st_d = CS_RND;
      CS_RND:  st_d = (cnt_q == ROUND_LAST) ? CS_FIN : CS_RND;
      CS_FIN:  st_d = CS_IDLE;
      default: st_d = CS_IDLE;
    endcase
  end

  always_comb begin
    load_en     = (st_q == CS_IDLE) && cmd_i.start;
    kw_en       = (st_q == CS_PRE) || (st_q == CS_RND);
    rnd_en      = (st_q == CS_RND);
    fin_en      = (st_q == CS_FIN);
    stat_o.busy = (st_q != CS_IDLE);
    stat_o.done = (st_q == CS_FIN);
    // The message word and constant for the next round are summed ahead of time and registered in kw_q.
    next_i      = (st_q == CS_RND) ? cnt_q + 6'd1 : 6'd0;
  end

  assign w_idx_o = msg_index(next_i);
  assign kw_next = round_k(next_i) + w_data_i;
  assign f       = round_fn(cnt_q[5:4], b_q, c_q, d_q);
  assign t       = a_q + f + kw_q;
  assign rot_w   = {t, t} << round_shift(cnt_q);
  assign new_b   = b_q + rot_w[63:32];
  assign chain_o = chain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= CS_IDLE;
      cnt_q   <= '0;
      chain_q <= {IV3, IV2, IV1, IV0};
    end else begin
      st_q <= st_d;
      if (st_q == CS_PRE) begin
        cnt_q <= '0;
      end else if (rnd_en) begin
        cnt_q <= cnt_q + 6'd1;
      end
      if (fin_en) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end else if (cmd_i.reinit) begin
        chain_q <= {IV3, IV2, IV1, IV0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (rnd_en) begin
      a_q <= d_q;
      b_q <= new_b;
      c_q <= b_q;
      d_q <= c_q;
    end
    if (kw_en) begin
      kw_q <= kw_next;
    end
  end

endmodule

// ----- rtl/md5sh_back.sv -----
// ----------------------------------------------------------------------------
// md5sh_back
// Block assembly, padding and digest output around the compression unit.
// ----------------------------------------------------------------------------
module md5sh_back import md5sh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  md5_in_t          q_item_i,
  output logic             q_pop_o,
  output comp_cmd_t        cmd_o,
  input  comp_stat_t       stat_i,
  input  logic [3:0]       w_idx_i,
  output logic [31:0]      w_data_o,
  input  logic [3:0][31:0] chain_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output md5_out_t         out_data_o
);

  back_state_e st_q, st_d;
  pad_phase_e  phase_q, phase_d;
  logic        pad_active_q, pad_active_d;
  logic [5:0]  fill_q;
  logic [63:0] bitcnt_q, len_q, bit_sum;
  logic [1:0]  wi_q;
  logic        out_valid_q;
  md5_out_t    out_q;
  logic [31:0] words_q [16];

  logic       push_en, take_last, load_out, blk_full;
  logic [7:0] push_byte, len_byte;

  assign len_byte = len_q[{fill_q[2:0], 3'b000} +: 8];
  assign bit_sum  = bitcnt_q + {60'd0, q_item_i.byte_present, 3'b000};
  assign blk_full = push_en && (fill_q == FILL_LAST);

  // Control outputs.
  always_comb begin
    q_pop_o      = 1'b0;
    push_en      = 1'b0;
    push_byte    = '0;
    take_last    = 1'b0;
    load_out     = 1'b0;
    cmd_o.reinit = 1'b0;
    case (st_q)
      BS_LOAD: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          push_en   = q_item_i.byte_present;
          push_byte = q_item_i.data_byte;
          take_last = q_item_i.last_item;
        end
      end
      BS_PAD: begin
        push_en = 1'b1;
        case (phase_q)
          PH_MARK: push_byte = PAD_MARK;
          PH_ZERO: push_byte = (fill_q == LEN_OFFSET) ? len_byte : 8'h00;
          PH_LEN:  push_byte = len_byte;
          default: push_byte = 8'h00;
        endcase
      end
      BS_COMP: begin
      end
      BS_OUT: begin
        load_out     = !out_valid_q || out_ready_i;
        cmd_o.reinit = load_out && (wi_q == WORD_LAST);
      end
      default: begin
      end
    endcase
    cmd_o.start = blk_full;
  end

  // Next state.
  always_comb begin
    case (st_q)
      BS_LOAD: begin
        if (blk_full) begin
          st_d = BS_COMP;
        end else if (take_last) begin
          st_d = BS_PAD;
        end else begin
          st_d = BS_LOAD;
        end
      end
      BS_PAD: st_d = blk_full ? BS_COMP : BS_PAD;
      BS_COMP: begin
        if (!stat_i.done) begin
          st_d = BS_COMP;
        end else if (pad_active_q && (phase_q == PH_LEN)) begin
          st_d = BS_OUT;
        end else if (pad_active_q) begin
          st_d = BS_PAD;
        end else begin
          st_d = BS_LOAD;
        end
      end
      BS_OUT:  st_d = cmd_o.reinit ? BS_LOAD : BS_OUT;
      default: st_d = BS_LOAD;
    endcase
  end

  // Padding bookkeeping.
  always_comb begin
    phase_d      = phase_q;
    pad_active_d = pad_active_q;
    if (take_last) begin
      phase_d      = PH_MARK;
      pad_active_d = 1'b1;
    end else if (st_q == BS_PAD) begin
      case (phase_q)
        PH_MARK: phase_d = PH_ZERO;
        PH_ZERO: phase_d = (fill_q == LEN_OFFSET) ? PH_LEN : PH_ZERO;
        PH_LEN:  phase_d = PH_LEN;
        default: phase_d = PH_MARK;
      endcase
    end
    if (cmd_o.reinit) begin
      pad_active_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= BS_LOAD;
      phase_q      <= PH_MARK;
      pad_active_q <= 1'b0;
      fill_q       <= '0;
      bitcnt_q     <= '0;
      wi_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      phase_q      <= phase_d;
      pad_active_q <= pad_active_d;
      if (push_en) begin
        fill_q <= fill_q + 6'd1;
      end
      if (take_last) begin
        bitcnt_q <= '0;
      end else if (q_pop_o) begin
        bitcnt_q <= bit_sum;
      end
      if (load_out) begin
        wi_q <= wi_q + 2'd1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      words_q[fill_q[5:2]][{fill_q[1:0], 3'b000} +: 8] <= push_byte;
    end
    if (take_last) begin
      len_q <= bit_sum;
    end
    if (load_out) begin
      out_q.digest_word <= chain_i[wi_q];
      out_q.word_index  <= wi_q;
      out_q.last_word   <= (wi_q == WORD_LAST);
    end
  end

  assign w_data_o    = words_q[w_idx_i];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/md5_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// md5_stream_hasher
// MD5 digest of a byte stream, four digest words out per message.
// ----------------------------------------------------------------------------
// Usage: each input transfer carries one message byte (byte_present = 1)
// and/or the end of the message (last_item = 1); an end with no byte
// closes the message as it stands, the empty message included. Transfers
// with neither flag are dropped. After the end, four output transfers give
// the digest words 0 to 3, first digest byte in bits 7:0, last_word on 3.
// A four-entry queue decouples input from processing. Each byte enters the
// block buffer as it is taken from the queue; every full 64-byte block then
// holds the back part in the round unit for a prefetch step, 64 rounds and
// the chaining update. Padding adds 9 to 72 byte steps and one or two more
// compressions before the digest appears, then each word leaves through a
// single output register.
// Reset clears the queue, counters and chaining words to the MD5 start
// values. A stalled receiver holds the output register; the back part then
// waits, and the queue fills and drops in_ready_o.
// ----------------------------------------------------------------------------
`include "md5_stream_hasher_assert.svh"

module md5_stream_hasher import md5sh_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  md5_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output md5_out_t out_data_o
);

  logic             q_valid, q_pop;
  md5_in_t          q_item;
  comp_cmd_t        cmd;
  comp_stat_t       stat;
  logic [3:0]       w_idx;
  logic [31:0]      w_data;
  logic [3:0][31:0] chain;

  md5sh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  md5sh_compress u_compress (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .w_idx_o  (w_idx),
    .w_data_i (w_data),
    .stat_o   (stat),
    .chain_o  (chain)
  );

  md5sh_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .w_idx_i     (w_idx),
    .w_data_o    (w_data),
    .chain_i     (chain),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `MD5SH_ASSERT_NOW(a_start_when_idle, cmd.start, !stat.busy, "compression started while busy")
  `MD5SH_ASSERT_NOW(a_pop_when_valid, q_pop, q_valid, "queue read while empty")
  `MD5SH_ASSERT_LATER(a_comp_latency, cmd.start, 66, stat.done, "compression did not end on time")
  `MD5SH_ASSERT_NOW(a_no_reinit_mid_comp, cmd.reinit, !stat.busy, "reinit during compression")

endmodule
